[design/kfr_pkg.sv]
`default_nettype none

package kfr_pkg;

   // Frame layout
   localparam logic [7:0] HDR_WATER  = 8'h01;
   localparam logic [7:0] HDR_AIR    = 8'h05;
   localparam logic [2:0] FRAME_LEN  = 3'd5;
   localparam int unsigned PAYLOAD_LEN = 4;

   // Register reset values
   localparam logic [7:0]  HEADER_GAP_RESET    = 8'd5;
   localparam logic [7:0]  BYTE_GAP_RESET      = 8'd7;
   localparam logic [15:0] STALE_TIMEOUT_RESET = 16'd1000;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_GAP    = 2'd0,
      CSR_BYTE_GAP      = 2'd1,
      CSR_STALE_TIMEOUT = 2'd2
   } csr_index_type;

   // Receive commands
   typedef enum logic {
      CMD_BYTE       = 1'b0,
      CMD_TIME_CHECK = 1'b1
   } command_type;

   typedef struct packed {
      logic        command;
      logic [7:0]  rx_byte;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic       frame_ok;
      logic       checksum_error;
      logic [7:0] rpm_code;
      logic [7:0] wheel_speed_code;
      logic [7:0] water_temp_code;
      logic [7:0] air_temp_code;
      logic       data_stale;
   } rsp_payload_type;

endpackage

`default_nettype wire

[design/kfr_if.sv]
`default_nettype none

interface kfr_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  rx_byte;
   logic [31:0] now_ms;

   modport source (output valid, command, rx_byte, now_ms, input ready);
   modport sink   (input valid, command, rx_byte, now_ms, output ready);
endinterface

interface kfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_ok;
   logic       checksum_error;
   logic [7:0] rpm_code;
   logic [7:0] wheel_speed_code;
   logic [7:0] water_temp_code;
   logic [7:0] air_temp_code;
   logic       data_stale;

   modport source (output valid, frame_ok, checksum_error, rpm_code, wheel_speed_code,
                   water_temp_code, air_temp_code, data_stale, input ready);
   modport sink   (input valid, frame_ok, checksum_error, rpm_code, wheel_speed_code,
                   water_temp_code, air_temp_code, data_stale, output ready);
endinterface

interface kfr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [kfr_pkg::CSR_INDEX_W-1:0]    index;
   logic [kfr_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/kline_frame_receiver_core.sv]
// Path: an accepted req_ch transaction passes the input register, then frame logic
// into the result register, before its rsp_ch transaction.
// Throughput: one transaction per cycle while rsp_ch is not stalled; the frame state updates as each advances.
// Reset: synchronous, active high; clears frame state (not the payload bytes), the latches
// and the config registers to their defaults, and sets the stale flag. No clearing pass is needed.
`default_nettype none

module kline_frame_receiver_core (
   input wire logic  clock,
   input wire logic  reset,
   kfr_req_if.sink   req_ch,
   kfr_rsp_if.source rsp_ch,
   kfr_csr_if.sink   csr_ch
);

   // ------------------------------------------------------------------
   // Configuration registers (always ready; to be written only while idle, which the block does not enforce)
   // ------------------------------------------------------------------
   logic [7:0]  header_gap_ff;
   logic [7:0]  byte_gap_ff;
   logic [15:0] stale_timeout_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_gap_ff    <= kfr_pkg::HEADER_GAP_RESET;
         byte_gap_ff      <= kfr_pkg::BYTE_GAP_RESET;
         stale_timeout_ff <= kfr_pkg::STALE_TIMEOUT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            kfr_pkg::CSR_HEADER_GAP:    header_gap_ff    <= csr_ch.data[7:0];
            kfr_pkg::CSR_BYTE_GAP:      byte_gap_ff      <= csr_ch.data[7:0];
            kfr_pkg::CSR_STALE_TIMEOUT: stale_timeout_ff <= csr_ch.data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline handshake: input register feeds the result register
   // ------------------------------------------------------------------
   logic                     in_valid_ff;
   kfr_pkg::req_payload_type in_data_ff;
   logic                     rsp_valid_ff;
   kfr_pkg::rsp_payload_type rsp_data_ff;
   logic                     rsp_free;
   logic                     advance;
   logic                     req_fire;

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && rsp_free;
   assign req_ch.ready = !in_valid_ff || rsp_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   // Capture the transaction payload; no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff.command <= req_ch.command;
         in_data_ff.rx_byte <= req_ch.rx_byte;
         in_data_ff.now_ms  <= req_ch.now_ms;
      end
   end

   // ------------------------------------------------------------------
   // Frame state
   // ------------------------------------------------------------------
   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  payload_ff [kfr_pkg::PAYLOAD_LEN];
   logic [31:0] last_byte_time_ff, last_byte_time_in;
   logic [31:0] last_frame_time_ff, last_frame_time_in;
   logic        stale_ff, stale_in;
   logic        is_water_ff, is_water_in;
   logic [7:0]  rpm_ff, rpm_in;
   logic [7:0]  speed_ff, speed_in;
   logic [7:0]  water_ff, water_in;
   logic [7:0]  air_ff, air_in;

   logic [31:0] byte_gap;
   logic [31:0] frame_age;
   logic [2:0]  left_dec;
   logic [1:0]  pos;
   logic [7:0]  sum;
   logic        is_byte;
   logic        in_frame_ok;
   logic        is_header;
   logic        pay_we;
   logic        frame_ok;
   logic        checksum_error;

   assign is_byte   = (in_data_ff.command == kfr_pkg::CMD_BYTE);
   assign byte_gap  = in_data_ff.now_ms - last_byte_time_ff;
   assign frame_age = in_data_ff.now_ms - last_frame_time_ff;
   assign left_dec  = bytes_left_ff - 3'd1;
   // Payload slot of this byte after the header (0..3); used only for payload bytes
   assign pos       = 2'((kfr_pkg::FRAME_LEN - 3'd1) - left_dec);
   assign sum       = payload_ff[0] + payload_ff[1] + payload_ff[2] + payload_ff[3];

   assign in_frame_ok = byte_gap < {24'd0, byte_gap_ff};
   assign is_header   = (byte_gap > {24'd0, header_gap_ff}) &&
                        ((in_data_ff.rx_byte == kfr_pkg::HDR_WATER) ||
                         (in_data_ff.rx_byte == kfr_pkg::HDR_AIR));

   always_comb begin
      bytes_left_in      = bytes_left_ff;
      last_byte_time_in  = last_byte_time_ff;
      last_frame_time_in = last_frame_time_ff;
      is_water_in        = is_water_ff;
      rpm_in             = rpm_ff;
      speed_in           = speed_ff;
      water_in           = water_ff;
      air_in             = air_ff;
      pay_we             = 1'b0;
      frame_ok           = 1'b0;
      checksum_error     = 1'b0;

      if (is_byte) begin
         last_byte_time_in = in_data_ff.now_ms;
         if (bytes_left_ff != 3'd0) begin
            if (in_frame_ok) begin
               bytes_left_in = left_dec;
               if (left_dec != 3'd0) begin
                  pay_we = 1'b1;
               end else if (sum == in_data_ff.rx_byte) begin
                  // Good frame: latch the readings
                  frame_ok           = 1'b1;
                  rpm_in             = payload_ff[0];
                  speed_in           = payload_ff[1];
                  last_frame_time_in = in_data_ff.now_ms;
                  if (is_water_ff) begin
                     water_in = payload_ff[3];
                  end else begin
                     air_in = payload_ff[3];
                  end
               end else begin
                  checksum_error = 1'b1;
               end
            end else begin
               // Late byte: drop the frame, do not treat it as a header
               bytes_left_in = 3'd0;
            end
         end else if (is_header) begin
            bytes_left_in = kfr_pkg::FRAME_LEN;
            is_water_in   = (in_data_ff.rx_byte == kfr_pkg::HDR_WATER);
         end
      end

      // A good frame restarts the age at zero, so it always clears stale
      if (frame_ok) begin
         stale_in = 1'b0;
      end else begin
         stale_in = stale_ff || (frame_age > {16'd0, stale_timeout_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff      <= 3'd0;
         last_byte_time_ff  <= 32'd0;
         last_frame_time_ff <= 32'd0;
         stale_ff           <= 1'b1;
         is_water_ff        <= 1'b0;
         rpm_ff             <= 8'd0;
         speed_ff           <= 8'd0;
         water_ff           <= 8'd0;
         air_ff             <= 8'd0;
      end else if (advance) begin
         bytes_left_ff      <= bytes_left_in;
         last_byte_time_ff  <= last_byte_time_in;
         last_frame_time_ff <= last_frame_time_in;
         stale_ff           <= stale_in;
         is_water_ff        <= is_water_in;
         rpm_ff             <= rpm_in;
         speed_ff           <= speed_in;
         water_ff           <= water_in;
         air_ff             <= air_in;
      end
   end

   // Payload bytes are only read after being written in the same frame
   always_ff @(posedge clock) begin
      if (advance && pay_we) begin
         payload_ff[pos] <= in_data_ff.rx_byte;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.frame_ok         <= frame_ok;
         rsp_data_ff.checksum_error   <= checksum_error;
         rsp_data_ff.rpm_code         <= rpm_in;
         rsp_data_ff.wheel_speed_code <= speed_in;
         rsp_data_ff.water_temp_code  <= water_in;
         rsp_data_ff.air_temp_code    <= air_in;
         rsp_data_ff.data_stale       <= stale_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.frame_ok         = rsp_data_ff.frame_ok;
   assign rsp_ch.checksum_error   = rsp_data_ff.checksum_error;
   assign rsp_ch.rpm_code         = rsp_data_ff.rpm_code;
   assign rsp_ch.wheel_speed_code = rsp_data_ff.wheel_speed_code;
   assign rsp_ch.water_temp_code  = rsp_data_ff.water_temp_code;
   assign rsp_ch.air_temp_code    = rsp_data_ff.air_temp_code;
   assign rsp_ch.data_stale       = rsp_data_ff.data_stale;

`ifndef ASSERT_OFF
   // Frame counter never runs past a full frame
   assert property (@(posedge clock) disable iff (reset)
      bytes_left_ff <= kfr_pkg::FRAME_LEN)
      else $error("bytes_left beyond frame length");

   // A completed frame is either good or bad, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.frame_ok && rsp_data_ff.checksum_error))
      else $error("frame_ok and checksum_error both set");

   // A good frame always clears the stale flag in the same transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_ok) |-> !rsp_data_ff.data_stale)
      else $error("good frame reported stale");

   // Hold a stalled result until the receiver takes it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

[tb/sv/kline_frame_receiver_core_test.sv]
`timescale 1ns / 1ps

module kline_frame_receiver_core_test;
   import kfr_pkg::*;

   // Run limits
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned ITEMS_PER_PHASE = 170;
   localparam int unsigned N_PHASES        = 8;
   localparam int unsigned SETTLE_CYCLES   = 6;
   localparam int unsigned TAIL_CYCLES     = 20;
   localparam int unsigned HOLDOFF_CYCLES  = 300;
   localparam int unsigned MAX_PRINTED     = 40;

   // Index past the end of the register map; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      command_type     cmd;
      logic [7:0]      data;
      logic [31:0]     at_ms;
      bit              typed;
      rsp_payload_type want;
   } directed_row_type;

   // Readouts written out by hand: ok, bad, rpm, speed, water, air, stale
   localparam rsp_payload_type UNTYPED    = '0;
   localparam rsp_payload_type IDLE_STALE = '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1};

   localparam int unsigned N_DIRECTED = 26;

   // Walked in order after reset with the register defaults (5, 7, 1000).
   directed_row_type directed_rows [N_DIRECTED] = '{
      // time check carrying a header value: ignored, still stale from reset
      '{CMD_TIME_CHECK, 8'h01, 32'd0,  1'b1, IDLE_STALE},
      // header exactly at the quiet gap: not accepted
      '{CMD_BYTE,       8'h01, 32'd5,  1'b1, IDLE_STALE},
      // water header one past the quiet gap, then payload at the edges of the byte range
      '{CMD_BYTE,       8'h01, 32'd11, 1'b1, IDLE_STALE},
      '{CMD_BYTE,       8'hFF, 32'd12, 1'b1, IDLE_STALE},
      '{CMD_BYTE,       8'hFF, 32'd13, 1'b1, IDLE_STALE},
      '{CMD_BYTE,       8'h00, 32'd14, 1'b1, IDLE_STALE},
      // one short of the byte gap: still in time
      '{CMD_BYTE,       8'hFF, 32'd20, 1'b1, IDLE_STALE},
      '{CMD_BYTE,       8'hFD, 32'd21, 1'b1,
        '{1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0}},
      // air header, sum wraps to 0x01, checksum off by one
      '{CMD_BYTE,       8'h05, 32'd27, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h80, 32'd28, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h80, 32'd29, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h80, 32'd30, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h81, 32'd31, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h02, 32'd32, 1'b1,
        '{1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0}},
      // same frame again with the wrapped checksum
      '{CMD_BYTE,       8'h05, 32'd40, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h80, 32'd41, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h80, 32'd42, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h80, 32'd43, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h81, 32'd44, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h01, 32'd45, 1'b1,
        '{1'b1, 1'b0, 8'h80, 8'h80, 8'hFF, 8'h81, 1'b0}},
      // late byte drops the frame and is not taken as a header
      '{CMD_BYTE,       8'h01, 32'd51, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h12, 32'd52, 1'b0, UNTYPED},
      '{CMD_BYTE,       8'h01, 32'd59, 1'b0, UNTYPED},
      // stale boundary: exactly the timeout, then one past it
      '{CMD_TIME_CHECK, 8'hFF, 32'd1045, 1'b0, UNTYPED},
      '{CMD_TIME_CHECK, 8'h00, 32'd1046, 1'b1,
        '{1'b0, 1'b0, 8'h80, 8'h80, 8'hFF, 8'h81, 1'b1}},
      // non-header byte at the top of the time range
      '{CMD_BYTE,       8'hFF, 32'hFFFF_FFFF, 1'b0, UNTYPED}
   };

   logic clock;
   logic reset;

   kfr_req_if req_ch ();
   kfr_rsp_if rsp_ch ();
   kfr_csr_if csr_ch ();

   kline_frame_receiver_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Register copies as the block should hold them
   logic [7:0]  cfg_header_gap;
   logic [7:0]  cfg_byte_gap;
   logic [15:0] cfg_stale_timeout;

   // Frame tracker state
   logic [2:0]  fr_bytes_left;
   logic [7:0]  fr_payload [PAYLOAD_LEN];
   logic [31:0] fr_last_byte_ms;
   logic [31:0] fr_last_frame_ms;
   logic        fr_stale;
   logic        fr_hdr_water;
   logic [7:0]  lat_rpm;
   logic [7:0]  lat_speed;
   logic [7:0]  lat_water;
   logic [7:0]  lat_air;

   rsp_payload_type readout_q [$];

   logic [31:0] stim_ms;
   int unsigned items_offered;
   int unsigned readouts_seen;
   int unsigned mismatch_count;
   int unsigned cycle_count;
   int unsigned holdoff_request;
   int unsigned sender_calm;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Bail out if the handshakes never complete.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at readout %0d: %s", readouts_seen, what);
   endtask

   task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%02h want 0x%02h", field, got, want));
   endtask

   task automatic reset_tracker();
      cfg_header_gap    = HEADER_GAP_RESET;
      cfg_byte_gap      = BYTE_GAP_RESET;
      cfg_stale_timeout = STALE_TIMEOUT_RESET;
      fr_bytes_left     = '0;
      foreach (fr_payload[k]) fr_payload[k] = '0;
      fr_last_byte_ms   = '0;
      fr_last_frame_ms  = '0;
      fr_stale          = 1'b1;
      fr_hdr_water      = 1'b0;
      lat_rpm           = '0;
      lat_speed         = '0;
      lat_water         = '0;
      lat_air           = '0;
   endtask

   // Advance the frame tracker by one transaction and return the readout it causes.
   function automatic rsp_payload_type predict_readout(logic cmd, logic [7:0] data,
                                                       logic [31:0] at_ms);
      rsp_payload_type r;
      logic [31:0]     since_byte;
      logic [2:0]      slot;
      logic [7:0]      total;
      r = '0;
      if (cmd == CMD_BYTE) begin
         since_byte = at_ms - fr_last_byte_ms;
         if (fr_bytes_left != 0) begin
            if (since_byte < 32'(cfg_byte_gap)) begin
               fr_bytes_left = fr_bytes_left - 3'd1;
               slot = FRAME_LEN - 3'd1 - fr_bytes_left;
               if (slot < 3'(PAYLOAD_LEN)) begin
                  fr_payload[slot[1:0]] = data;
               end else begin
                  total = fr_payload[0] + fr_payload[1] + fr_payload[2] + fr_payload[3];
                  if (total == data) begin
                     r.frame_ok = 1'b1;
                     lat_rpm    = fr_payload[0];
                     lat_speed  = fr_payload[1];
                     if (fr_hdr_water)
                        lat_water = fr_payload[3];
                     else
                        lat_air = fr_payload[3];
                     fr_stale         = 1'b0;
                     fr_last_frame_ms = at_ms;
                  end else begin
                     r.checksum_error = 1'b1;
                  end
               end
            end else begin
               // late byte: drop the frame, do not restart on it
               fr_bytes_left = '0;
            end
         end else if (since_byte > 32'(cfg_header_gap) &&
                      (data == HDR_WATER || data == HDR_AIR)) begin
            fr_bytes_left = FRAME_LEN;
            fr_hdr_water  = (data == HDR_WATER);
         end
         fr_last_byte_ms = at_ms;
      end
      if (!fr_stale && (at_ms - fr_last_frame_ms) > 32'(cfg_stale_timeout))
         fr_stale = 1'b1;
      r.rpm_code         = lat_rpm;
      r.wheel_speed_code = lat_speed;
      r.water_temp_code  = lat_water;
      r.air_temp_code    = lat_air;
      r.data_stale       = fr_stale;
      return r;
   endfunction

   // Sender gaps: mostly none, some short, a few long, with calm stretches.
   function automatic int unsigned sender_idle();
      int unsigned roll;
      if (sender_calm != 0) begin
         sender_calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3)
         sender_calm = $urandom_range(20, 60);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one transaction, hold it until accepted, then queue its expected readout.
   task automatic offer(logic cmd, logic [7:0] data, logic [31:0] at_ms);
      int unsigned idle;
      idle = sender_idle();
      if (idle != 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.rx_byte <= data;
      req_ch.now_ms  <= at_ms;
      do @(posedge clock); while (!req_ch.ready);
      readout_q.push_back(predict_readout(cmd, data, at_ms));
      stim_ms = at_ms;
      items_offered++;
   endtask

   task automatic send_byte(logic [7:0] data, logic [31:0] step_ms);
      offer(CMD_BYTE, data, stim_ms + step_ms);
   endtask

   // Spacing that keeps a frame alive under the current byte gap.
   function automatic logic [31:0] frame_spacing();
      if (cfg_byte_gap == 0) return '0;
      return $urandom_range(0, 32'(cfg_byte_gap) - 1);
   endfunction

   // Well-formed frame with random content; sometimes a bad checksum or a late one.
   task automatic send_frame();
      logic [7:0] hdr;
      logic [7:0] body;
      logic [7:0] sum;
      hdr = ($urandom_range(0, 1) != 0) ? HDR_WATER : HDR_AIR;
      send_byte(hdr, 32'(cfg_header_gap) + 1 + $urandom_range(0, 2));
      sum = '0;
      for (int k = 0; k < PAYLOAD_LEN; k++) begin
         body = 8'($urandom);
         sum  = sum + body;
         send_byte(body, frame_spacing());
      end
      if ($urandom_range(0, 7) == 0)
         sum = sum ^ 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 11) == 0)
         send_byte(sum, 32'(cfg_byte_gap) + $urandom_range(0, 2));
      else
         send_byte(sum, frame_spacing());
   endtask

   // Stray bytes, time checks, boundary probes and jumps in time.
   task automatic send_noise();
      case ($urandom_range(0, 5))
         0: send_byte(8'($urandom), $urandom_range(0, 12));
         1: offer(CMD_TIME_CHECK, 8'($urandom), stim_ms + $urandom_range(0, 50));
         2: offer(CMD_TIME_CHECK, 8'($urandom),
                  fr_last_frame_ms + 32'(cfg_stale_timeout) + $urandom_range(0, 1));
         3: offer(CMD_BYTE, ($urandom_range(0, 1) != 0) ? HDR_WATER : HDR_AIR,
                  fr_last_byte_ms + 32'(cfg_header_gap));
         4: offer(1'($urandom_range(0, 1)), 8'($urandom), $urandom);
         default: offer(CMD_TIME_CHECK, 8'($urandom),
                        stim_ms + 32'(cfg_stale_timeout) / 2 + $urandom_range(0, 200));
      endcase
   endtask

   task automatic random_mix(int unsigned count);
      int unsigned start;
      start = items_offered;
      while (items_offered - start < count) begin
         if ($urandom_range(0, 3) != 0)
            send_frame();
         else
            send_noise();
      end
   endtask

   // Drop valid and wait until every expected readout has come back.
   task automatic drain_readouts();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (readout_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves valid high after the handshake; the caller drops it after the last write.
   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_HEADER_GAP:    cfg_header_gap    = value[7:0];
         CSR_BYTE_GAP:      cfg_byte_gap      = value[7:0];
         CSR_STALE_TIMEOUT: cfg_stale_timeout = value;
         default: ;
      endcase
   endtask

   // Upper data bits carry junk on the 8-bit registers; the block must mask them.
   task automatic program_registers(logic [7:0] hdr_gap, logic [7:0] byte_gap,
                                    logic [15:0] timeout, bit poke_spare);
      csr_write(CSR_HEADER_GAP, {8'($urandom), hdr_gap});
      csr_write(CSR_BYTE_GAP, {8'($urandom), byte_gap});
      csr_write(CSR_STALE_TIMEOUT, timeout);
      if (poke_spare)
         csr_write(CSR_SPARE, 16'hFFFF);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: random stalls, calm stretches, and a long hold-off on request.
   initial begin
      int unsigned stall_left;
      int unsigned calm_left;
      int unsigned roll;
      stall_left   = 0;
      calm_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request != 0) begin
            rsp_ch.ready <= 1'b0;
            holdoff_request--;
         end else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (calm_left != 0) begin
               calm_left--;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 20)
                  stall_left = $urandom_range(1, 3);
               else if (roll < 23)
                  stall_left = $urandom_range(10, 40);
               else if (roll < 26)
                  calm_left = $urandom_range(20, 80);
            end
         end
      end
   end

   // Compare each accepted readout with the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (readout_q.size() == 0) begin
            report_mismatch("readout with no transaction pending");
         end else begin
            want = readout_q.pop_front();
            check_field("frame_ok", 8'(rsp_ch.frame_ok), 8'(want.frame_ok));
            check_field("checksum_error", 8'(rsp_ch.checksum_error),
                        8'(want.checksum_error));
            check_field("rpm_code", rsp_ch.rpm_code, want.rpm_code);
            check_field("wheel_speed_code", rsp_ch.wheel_speed_code, want.wheel_speed_code);
            check_field("water_temp_code", rsp_ch.water_temp_code, want.water_temp_code);
            check_field("air_temp_code", rsp_ch.air_temp_code, want.air_temp_code);
            check_field("data_stale", 8'(rsp_ch.data_stale), 8'(want.data_stale));
         end
         readouts_seen++;
      end
   end

   initial begin
      logic [7:0]  hdr_gap;
      logic [7:0]  byte_gap;
      logic [15:0] timeout;
      items_offered   = 0;
      readouts_seen   = 0;
      mismatch_count  = 0;
      cycle_count     = 0;
      holdoff_request = 0;
      sender_calm     = 0;
      stim_ms         = '0;
      reset_tracker();

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_BYTE;
      req_ch.rx_byte = '0;
      req_ch.now_ms  = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_HEADER_GAP;
      csr_ch.data    = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under the reset register values; typed rows override the tracker.
      foreach (directed_rows[i]) begin
         offer(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].at_ms);
         if (directed_rows[i].typed)
            readout_q[readout_q.size() - 1] = directed_rows[i].want;
      end

      // Keep going on the defaults; time wraps right away from the last row.
      random_mix(ITEMS_PER_PHASE);

      for (int p = 0; p < N_PHASES; p++) begin
         drain_readouts();
         case (p)
            0: begin hdr_gap = 8'd0;   byte_gap = 8'd255; timeout = 16'd0;     end
            1: begin hdr_gap = 8'd255; byte_gap = 8'd1;   timeout = 16'hFFFF;  end
            2: begin hdr_gap = 8'd255; byte_gap = 8'd255; timeout = 16'hFFFF;  end
            3: begin hdr_gap = 8'd0;   byte_gap = 8'd0;   timeout = 16'd1;     end
            N_PHASES - 1: begin
               hdr_gap  = HEADER_GAP_RESET;
               byte_gap = BYTE_GAP_RESET;
               timeout  = STALE_TIMEOUT_RESET;
            end
            default: begin
               hdr_gap  = 8'($urandom_range(0, 12));
               byte_gap = 8'($urandom_range(2, 20));
               timeout  = 16'($urandom_range(0, 3000));
            end
         endcase
         program_registers(hdr_gap, byte_gap, timeout, p == 0);
         random_mix(ITEMS_PER_PHASE / 2);
         // Hold off the receiver while the sender keeps pushing, so the block backs up.
         if (p == 1)
            holdoff_request = HOLDOFF_CYCLES;
         // Pause the sender until everything in flight has come back.
         if (p == 2)
            drain_readouts();
         random_mix(ITEMS_PER_PHASE / 2);
      end

      drain_readouts();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
design/kfr_pkg.sv
design/kfr_if.sv
design/kline_frame_receiver_core.sv
tb/sv/kline_frame_receiver_core_test.sv
